// ===== src/bmi_pkg.sv =====
// ----------------------------------------------------------------------------
// bmi_pkg
// Shared types and constants of the batch modular inverter.
// ----------------------------------------------------------------------------
package bmi_pkg;

    localparam int DATA_W = 64;
    localparam int IDX_W  = 6;
    localparam int ADDR_W = 4;

    // register index as decoded from paddr[3]
    localparam logic REG_MODULUS = 1'b0;
    localparam logic [DATA_W-1:0] MODULUS_RST = 64'd2;

    typedef enum logic [0:0] {
        ALU_DIV,
        ALU_MULMOD
    } t_alu_op;

    typedef struct packed {
        logic    start;
        t_alu_op op;
    } t_alu_cmd;

    typedef enum logic [4:0] {
        S_IDLE,
        S_RED,
        S_PRD_RD,
        S_PRD_GO,
        S_PRD_MUL,
        S_STORE,
        S_EU_CHK,
        S_EU_DIV,
        S_EU_MQ_GO,
        S_EU_MQ,
        S_EU_MUL_GO,
        S_EU_MUL,
        S_WALK,
        S_WK_GO1,
        S_WK_M1,
        S_WK_M2,
        S_WK_OUT
    } t_state;

endpackage

// ===== src/bmi_alu.sv =====
// ----------------------------------------------------------------------------
// bmi_alu
// Bit-serial shared unit: 64-bit restoring divide (one quotient bit per
// cycle) and modular multiply by double-and-add (a double step and a conditional add step per bit).
// ----------------------------------------------------------------------------
module bmi_alu import bmi_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_alu_cmd          i_cmd,
    input  logic [DATA_W-1:0] i_a,
    input  logic [DATA_W-1:0] i_m,
    input  logic [DATA_W-1:0] i_d,
    output logic              o_done,
    output logic [DATA_W-1:0] o_quo,
    output logic [DATA_W-1:0] o_rem
);

    logic              r_busy;
    logic              r_done;
    t_alu_op           r_op;
    logic [IDX_W-1:0]  r_cnt;
    logic              r_ph;
    logic [DATA_W-1:0] r_acc;
    logic [DATA_W-1:0] r_x;
    logic [DATA_W-1:0] r_a;
    logic [DATA_W-1:0] r_d;

    logic [DATA_W:0]   s_rem;
    logic [DATA_W:0]   s_sum;
    logic [DATA_W:0]   s_addin;
    logic [DATA_W:0]   s_red;
    logic              s_ge;
    logic [DATA_W-1:0] s_step;
    logic              s_last;

    always_comb begin
        s_rem   = {r_acc, r_x[DATA_W-1]};
        s_sum   = {1'b0, r_acc} + {1'b0, (r_ph ? r_a : r_acc)};
        s_addin = (r_op == ALU_DIV) ? s_rem : s_sum;
        // a carry out of the add also means "at least n"
        s_ge    = (s_addin >= {1'b0, r_d});
        s_red   = s_addin - {1'b0, r_d};
        s_step  = s_ge ? s_red[DATA_W-1:0] : s_addin[DATA_W-1:0];
        s_last  = (r_cnt == IDX_W'(DATA_W - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_ph   <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_ph   <= 1'b0;
            end else if (r_busy) begin
                if (r_op == ALU_DIV || r_ph) begin
                    r_cnt <= r_cnt + 1'b1;
                    r_ph  <= 1'b0;
                    if (s_last) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end
                end else begin
                    r_ph <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_op  <= i_cmd.op;
            r_acc <= '0;
            r_x   <= (i_cmd.op == ALU_DIV) ? i_a : i_m;
            r_a   <= i_a;
            r_d   <= i_d;
        end else if (r_busy) begin
            if (r_op == ALU_DIV) begin
                r_acc <= s_step;
                r_x   <= {r_x[DATA_W-2:0], s_ge};
            end else if (!r_ph) begin
                r_acc <= s_step;
            end else begin
                if (r_x[DATA_W-1]) begin
                    r_acc <= s_step;
                end
                r_x <= {r_x[DATA_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_x;
    assign o_rem  = r_acc;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.start |-> !r_busy) else $error("alu started while busy");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy) else $error("alu done while still busy");
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy)) else $error("alu done without a run");

endmodule

// ===== src/batch_modular_inverse.sv =====
// ----------------------------------------------------------------------------
// batch_modular_inverse
// Batch inversion modulo n: stores elements and prefix products, inverts the
// full product once by extended Euclid, then walks back emitting inverses.
// ----------------------------------------------------------------------------
// Usage:
//   Input words (element_value, is_last) arrive on i_in_valid / o_in_ready.
//   Each is reduced mod n and folded into the prefix product. A word with
//   is_last set, or the one that fills MAX_BATCH entries, closes the batch.
//   Output words (inverse, index, not_invertible, batch_done) leave on
//   o_out_valid / i_out_ready, highest index first; index 0 carries
//   batch_done. A non-invertible batch gives inverse 0 with the flag set.
//   One shared bit-serial unit does all divides and modular multiplies.
//   Closing a batch runs extended Euclid, at most about 93 iterations,
//   then walks back over the stored prefix products emitting words.
//   Only one word is worked on at a time; o_in_ready is high when idle.
//   A stalled receiver holds the walk at the output register; the last
//   word may still wait there while a new batch is taken in.
//   Reset empties the batch and sets the modulus to 2. The modulus is at
//   byte address 0 of the 64-bit APB port; the user must see that it is
//   written only while idle, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
module batch_modular_inverse import bmi_pkg::*; #(
    parameter int MAX_BATCH = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [DATA_W-1:0] i_element_value,
    input  logic              i_is_last,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [DATA_W-1:0] o_inverse_value,
    output logic [IDX_W-1:0]  o_element_index,
    output logic              o_not_invertible,
    output logic              o_batch_done,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    localparam int AW = (MAX_BATCH > 1) ? $clog2(MAX_BATCH) : 1;

    logic [DATA_W-1:0] mem_elem [MAX_BATCH];
    logic [DATA_W-1:0] mem_pref [MAX_BATCH];

    t_state            r_state, n_state;
    logic [IDX_W-1:0]  r_cnt, n_cnt;
    logic [IDX_W-1:0]  r_k, n_k;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic              r_close, n_close;
    logic              r_okm, n_okm;
    logic              r_ok, n_ok;
    logic [DATA_W-1:0] r_n;
    logic [DATA_W-1:0] r_v, n_v;
    logic [DATA_W-1:0] r_p, n_p;
    logic [DATA_W-1:0] r_inv, n_inv;
    logic [DATA_W-1:0] r_r0, n_r0;
    logic [DATA_W-1:0] r_r1, n_r1;
    logic [DATA_W-1:0] r_t0, n_t0;
    logic [DATA_W-1:0] r_t1, n_t1;
    logic [DATA_W-1:0] r_q, n_q;
    logic [DATA_W-1:0] r_r2, n_r2;
    logic [DATA_W-1:0] r_res, n_res;
    logic [DATA_W-1:0] r_rd_elem, r_rd_pref;
    logic              r_o_valid, n_o_valid;
    logic [DATA_W-1:0] r_o_inv;
    logic [IDX_W-1:0]  r_o_idx;
    logic              r_o_ni, r_o_done;

    logic              s_in_acc;
    logic              s_load;
    logic              s_we;
    logic              s_rd_en;
    logic [IDX_W-1:0]  s_k_m1, s_idx_m1;
    logic [AW-1:0]     s_rd_paddr;
    logic [DATA_W:0]   s_diff;
    logic [DATA_W-1:0] s_t2;
    logic              s_cfg_we;

    t_alu_cmd          s_cmd;
    logic [DATA_W-1:0] s_a, s_m, s_d;
    logic              s_done;
    logic [DATA_W-1:0] s_quo, s_rem;

    bmi_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (s_cmd),
        .i_a     (s_a),
        .i_m     (s_m),
        .i_d     (s_d),
        .o_done  (s_done),
        .o_quo   (s_quo),
        .o_rem   (s_rem)
    );

    assign s_in_acc = i_in_valid && o_in_ready;
    assign s_k_m1   = r_k - 1'b1;
    assign s_idx_m1 = r_idx - 1'b1;
    assign s_rd_paddr = (r_state == S_PRD_RD) ? s_k_m1[AW-1:0] : s_idx_m1[AW-1:0];

    // t0 - qt, wrapped back into range when it borrows
    assign s_diff = {1'b0, r_t0} - {1'b0, s_rem};
    assign s_t2   = s_diff[DATA_W] ? (s_diff[DATA_W-1:0] + r_n) : s_diff[DATA_W-1:0];

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_k       = r_k;
        n_idx     = r_idx;
        n_close   = r_close;
        n_okm     = r_okm;
        n_ok      = r_ok;
        n_v       = r_v;
        n_p       = r_p;
        n_inv     = r_inv;
        n_r0      = r_r0;
        n_r1      = r_r1;
        n_t0      = r_t0;
        n_t1      = r_t1;
        n_q       = r_q;
        n_r2      = r_r2;
        n_res     = r_res;
        o_in_ready = 1'b0;
        s_load    = 1'b0;
        s_we      = 1'b0;
        s_rd_en   = 1'b0;
        s_cmd     = '{start: 1'b0, op: ALU_DIV};
        s_a       = i_element_value;
        s_m       = r_v;
        s_d       = r_n;

        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_k     = r_cnt;
                    n_close = i_is_last || (r_cnt == IDX_W'(MAX_BATCH - 1));
                    n_okm   = (r_n >= 64'd2);
                    if (r_n >= 64'd2) begin
                        s_cmd   = '{start: 1'b1, op: ALU_DIV};
                        n_state = S_RED;
                    end else begin
                        n_v     = '0;
                        n_p     = '0;
                        n_state = S_STORE;
                    end
                end
            end
            S_RED: begin
                if (s_done) begin
                    n_v = s_rem;
                    if (r_k == '0) begin
                        n_p     = s_rem;
                        n_state = S_STORE;
                    end else begin
                        n_state = S_PRD_RD;
                    end
                end
            end
            S_PRD_RD: begin
                s_rd_en = 1'b1;
                n_state = S_PRD_GO;
            end
            S_PRD_GO: begin
                s_cmd   = '{start: 1'b1, op: ALU_MULMOD};
                s_a     = r_rd_pref;
                s_m     = r_v;
                n_state = S_PRD_MUL;
            end
            S_PRD_MUL: begin
                if (s_done) begin
                    n_p     = s_rem;
                    n_state = S_STORE;
                end
            end
            S_STORE: begin
                s_we = 1'b1;
                if (!r_close) begin
                    n_cnt   = r_k + 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_cnt = '0;
                    n_idx = r_k;
                    n_inv = '0;
                    if (!r_okm) begin
                        n_ok    = 1'b0;
                        n_state = S_WALK;
                    end else begin
                        n_r0    = r_n;
                        n_r1    = r_p;
                        n_t0    = '0;
                        n_t1    = 64'd1;
                        n_state = S_EU_CHK;
                    end
                end
            end
            S_EU_CHK: begin
                if (r_r1 == '0) begin
                    n_ok    = (r_r0 == 64'd1);
                    n_inv   = r_t0;
                    n_state = S_WALK;
                end else begin
                    s_cmd   = '{start: 1'b1, op: ALU_DIV};
                    s_a     = r_r0;
                    s_d     = r_r1;
                    n_state = S_EU_DIV;
                end
            end
            S_EU_DIV: begin
                if (s_done) begin
                    n_q     = s_quo;
                    n_r2    = s_rem;
                    n_state = S_EU_MQ_GO;
                end
            end
            S_EU_MQ_GO: begin
                s_cmd   = '{start: 1'b1, op: ALU_DIV};
                s_a     = r_q;
                n_state = S_EU_MQ;
            end
            S_EU_MQ: begin
                if (s_done) begin
                    n_q     = s_rem;
                    n_state = S_EU_MUL_GO;
                end
            end
            S_EU_MUL_GO: begin
                s_cmd   = '{start: 1'b1, op: ALU_MULMOD};
                s_a     = r_q;
                s_m     = r_t1;
                n_state = S_EU_MUL;
            end
            S_EU_MUL: begin
                if (s_done) begin
                    n_r0    = r_r1;
                    n_r1    = r_r2;
                    n_t0    = r_t1;
                    n_t1    = s_t2;
                    n_state = S_EU_CHK;
                end
            end
            S_WALK: begin
                // also the output stage for index 0 and for a failed batch: holds here until the word register frees
                if (!r_ok) begin
                    n_res = '0;
                end else if (r_idx == '0) begin
                    n_res = r_inv;
                end
                if (!r_ok || r_idx == '0) begin
                    if (!r_o_valid || i_out_ready) begin
                        s_load = 1'b1;
                        if (r_idx == '0) begin
                            n_state = S_IDLE;
                        end else begin
                            n_idx = s_idx_m1;
                        end
                    end
                end else begin
                    s_rd_en = 1'b1;
                    n_state = S_WK_GO1;
                end
            end
            S_WK_GO1: begin
                s_cmd   = '{start: 1'b1, op: ALU_MULMOD};
                s_a     = r_inv;
                s_m     = r_rd_pref;
                n_state = S_WK_M1;
            end
            S_WK_M1: begin
                if (s_done) begin
                    n_res = s_rem;
                    s_cmd = '{start: 1'b1, op: ALU_MULMOD};
                    s_a   = r_inv;
                    s_m   = r_rd_elem;
                    n_state = S_WK_M2;
                end
            end
            S_WK_M2: begin
                if (s_done) begin
                    n_inv   = s_rem;
                    n_state = S_WK_OUT;
                end
            end
            S_WK_OUT: begin
                // word of a nonzero index, held until the word register frees
                if (!r_o_valid || i_out_ready) begin
                    s_load  = 1'b1;
                    n_idx   = s_idx_m1;
                    n_state = S_WALK;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_o_valid = r_o_valid && !i_out_ready;
        if (s_load) begin
            n_o_valid = 1'b1;
        end
    end

    assign s_cfg_we = psel && penable && pwrite && pready && (paddr[3] == REG_MODULUS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_o_valid <= 1'b0;
            r_n       <= MODULUS_RST;
            r_inv     <= '0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_o_valid <= n_o_valid;
            r_inv     <= n_inv;
            if (s_cfg_we) begin
                r_n <= pwdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_k     <= n_k;
        r_idx   <= n_idx;
        r_close <= n_close;
        r_okm   <= n_okm;
        r_ok    <= n_ok;
        r_v     <= n_v;
        r_p     <= n_p;
        r_r0    <= n_r0;
        r_r1    <= n_r1;
        r_t0    <= n_t0;
        r_t1    <= n_t1;
        r_q     <= n_q;
        r_r2    <= n_r2;
        r_res   <= n_res;
        if (s_load) begin
            r_o_inv  <= n_res;
            r_o_idx  <= r_idx;
            r_o_ni   <= !r_ok;
            r_o_done <= (r_idx == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_we) begin
            mem_elem[r_k[AW-1:0]] <= r_v;
            mem_pref[r_k[AW-1:0]] <= r_p;
        end
        if (s_rd_en) begin
            r_rd_elem <= mem_elem[r_idx[AW-1:0]];
            r_rd_pref <= mem_pref[s_rd_paddr];
        end
    end

    assign o_out_valid      = r_o_valid;
    assign o_inverse_value  = r_o_inv;
    assign o_element_index  = r_o_idx;
    assign o_not_invertible = r_o_ni;
    assign o_batch_done     = r_o_done;
    assign pready           = 1'b1;
    assign prdata           = (paddr[3] == REG_MODULUS) ? r_n : '0;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_in_acc |=> !o_in_ready) else $error("input taken while busy");
    a_end_of_batch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_load && r_idx == '0) |=> (r_state == S_IDLE && r_cnt == '0))
        else $error("batch not closed after index 0");
    a_noninv_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_not_invertible) |-> (o_inverse_value == '0))
        else $error("non-invertible word with nonzero value");

endmodule

// ===== tb/tb_batch_modular_inverse.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_batch_modular_inverse
// Drives batches of elements under several moduli and checks every inverse
// word, index and flag against a behavioral model of batch inversion.
// ----------------------------------------------------------------------------
module tb_batch_modular_inverse;
    import bmi_pkg::*;

    localparam int MAXB      = 64;
    localparam int WDOG_MAX  = 400000;

    typedef struct {
        logic [DATA_W-1:0] value;
        logic              last;
    } t_elem;

    typedef struct {
        logic [DATA_W-1:0] inv;
        logic [IDX_W-1:0]  idx;
        logic              bad;
        logic              done;
    } t_inv_word;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    logic [DATA_W-1:0] i_element_value = '0;
    logic              i_is_last = 1'b0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic [DATA_W-1:0] o_inverse_value;
    logic [IDX_W-1:0]  o_element_index;
    logic              o_not_invertible;
    logic              o_batch_done;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    batch_modular_inverse dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_elem     pending_elems[$];
    t_inv_word expected_inverses[$];
    int        error_count = 0;
    int        watchdog = 0;
    bit        calm = 1'b0;   // no idling on either side

    // model state
    logic [DATA_W-1:0] mdl_modulus;
    logic [DATA_W-1:0] mdl_elems[MAXB];
    logic [DATA_W-1:0] mdl_prefix[MAXB];
    int                mdl_count;

    function automatic logic [DATA_W-1:0] add_mod(logic [DATA_W-1:0] x, logic [DATA_W-1:0] y,
                                                  logic [DATA_W-1:0] n);
        logic [DATA_W:0] s;
        s = {1'b0, x} + {1'b0, y};
        if (s >= {1'b0, n}) s = s - {1'b0, n};
        return s[DATA_W-1:0];
    endfunction

    function automatic logic [DATA_W-1:0] mul_mod(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b,
                                                  logic [DATA_W-1:0] n);
        logic [DATA_W-1:0] r;
        r = '0;
        for (int i = DATA_W - 1; i >= 0; i--) begin
            r = add_mod(r, r, n);
            if (b[i]) r = add_mod(r, a, n);
        end
        return r;
    endfunction

    // extended Euclid; ok is 0 when gcd(a, n) != 1
    function automatic void euclid_inverse(logic [DATA_W-1:0] a, logic [DATA_W-1:0] n,
                                           output bit ok, output logic [DATA_W-1:0] inv);
        logic [DATA_W-1:0] r0, r1, r2, t0, t1, t2, q, qt;
        r0 = n; r1 = a; t0 = '0; t1 = 1;
        while (r1 != 0) begin
            q  = r0 / r1;
            r2 = r0 - q * r1;
            qt = mul_mod(q % n, t1, n);
            t2 = (t0 >= qt) ? t0 - qt : t0 + (n - qt);
            r0 = r1; r1 = r2; t0 = t1; t1 = t2;
        end
        ok  = (r0 == 1);
        inv = t0;
    endfunction

    task automatic predict_inverses(t_elem e);
        logic [DATA_W-1:0] n, v, run, r;
        bit                ok_mod, ok;
        int                k;
        n      = mdl_modulus;
        ok_mod = n >= 2;
        v      = ok_mod ? e.value % n : '0;
        k      = mdl_count % MAXB;
        mdl_elems[k]  = v;
        mdl_prefix[k] = (k == 0 || !ok_mod) ? v : mul_mod(mdl_prefix[k-1], v, n);
        mdl_count = k + 1;
        if (!e.last && mdl_count < MAXB) return;
        mdl_count = 0;
        run = '0;
        ok  = 1'b0;
        if (ok_mod) euclid_inverse(mdl_prefix[k], n, ok, run);
        for (int idx = k; idx >= 0; idx--) begin
            t_inv_word w;
            if (!ok) r = '0;
            else if (idx > 0) begin
                r   = mul_mod(run, mdl_prefix[idx-1], n);
                run = mul_mod(run, mdl_elems[idx], n);
            end else r = run;
            w.inv = r; w.idx = idx[IDX_W-1:0]; w.bad = !ok; w.done = (idx == 0);
            expected_inverses.push_back(w);
        end
    endtask

    task automatic report_mismatch(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] exp);
        $display("MISMATCH %s: got %0h expected %0h", what, got, exp);
        error_count++;
    endtask

    // acceptance seen at the last rising edge; the driver moves on only after it
    bit in_taken;
    always @(posedge i_clk) in_taken <= i_in_valid && o_in_ready;

    // driver
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_in_valid || in_taken) begin
                if (pending_elems.size() > 0 && (calm || $urandom_range(99) >= 10)) begin
                    t_elem e;
                    e = pending_elems.pop_front();
                    predict_inverses(e);
                    i_in_valid      <= 1'b1;
                    i_element_value <= e.value;
                    i_is_last       <= e.last;
                end else i_in_valid <= 1'b0;
            end
            i_out_ready <= calm || $urandom_range(99) >= 10;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || psel) watchdog <= 0;
            else watchdog <= watchdog + 1;
            if (o_out_valid && i_out_ready) begin
                if (expected_inverses.size() == 0) begin
                    report_mismatch("unexpected word index", DATA_W'(o_element_index), '0);
                end else begin
                    t_inv_word w;
                    w = expected_inverses.pop_front();
                    if (o_inverse_value !== w.inv) report_mismatch("inverse", o_inverse_value, w.inv);
                    if (o_element_index !== w.idx) report_mismatch("index", o_element_index, w.idx);
                    if (o_not_invertible !== w.bad)
                        report_mismatch("not_invertible", o_not_invertible, w.bad);
                    if (o_batch_done !== w.done) report_mismatch("batch_done", o_batch_done, w.done);
                end
            end
            if (watchdog > WDOG_MAX) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    task automatic wait_drained();
        while (pending_elems.size() > 0 || i_in_valid || expected_inverses.size() > 0)
            @(posedge i_clk);
        repeat (600) @(posedge i_clk);
    endtask

    task automatic write_modulus(logic [DATA_W-1:0] n);
        @(negedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= '0; pwdata <= n;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        mdl_modulus = n;
    endtask

    task automatic push_elem(logic [DATA_W-1:0] v, logic last);
        t_elem e;
        e.value = v; e.last = last;
        pending_elems.push_back(e);
    endtask

    function automatic logic [DATA_W-1:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic random_batches(int items, logic [DATA_W-1:0] n);
        int left, len;
        left = items;
        while (left > 0) begin
            len = ($urandom_range(19) == 0) ? $urandom_range(MAXB, 40) : $urandom_range(6, 1);
            if (len > left) len = left;
            for (int i = 0; i < len; i++) begin
                logic [DATA_W-1:0] v;
                case ($urandom_range(9))
                    0:       v = rand64();
                    1:       v = '0;
                    default: v = (n == 0) ? rand64() : rand64() % n;
                endcase
                push_elem(v, (i == len - 1) && len < MAXB);
            end
            left -= len;
        end
    endtask

    initial begin
        mdl_modulus = MODULUS_RST;
        mdl_count   = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset modulus 2: element 1 inverts, 0 does not
        push_elem(1, 1'b1);
        push_elem(0, 1'b1);
        wait_drained();

        write_modulus(64'hFFFF_FFFF_FFFF_FFC5);   // largest 64-bit prime
        push_elem(64'hFFFF_FFFF_FFFF_FFC4, 1'b0);
        push_elem(1, 1'b0);
        push_elem(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);  // unreduced
        push_elem(12345, 1'b1);
        push_elem(0, 1'b0);                        // zero element poisons batch
        push_elem(7, 1'b1);
        for (int i = 0; i < MAXB; i++) push_elem(i + 2, 1'b0);  // capacity closes
        wait_drained();

        write_modulus(64'hFFFF_FFFF_FFFF_FFFF);
        push_elem(6, 1'b0); push_elem(2, 1'b1);
        push_elem(64'hFFFF_FFFF_FFFF_FFFE, 1'b1);
        wait_drained();
        write_modulus(0);
        push_elem(5, 1'b1);
        wait_drained();
        write_modulus(1);
        push_elem(5, 1'b0); push_elem(3, 1'b1);
        wait_drained();

        write_modulus(64'd1000003);
        random_batches(100, 64'd1000003);
        wait_drained();

        // stretch with no idling
        calm = 1'b1;
        write_modulus(64'hFFFF_FFFF_FFFF_FFC5);
        random_batches(100, 64'hFFFF_FFFF_FFFF_FFC5);
        wait_drained();
        calm = 1'b0;

        write_modulus(64'd360360);  // highly composite: many failing batches
        random_batches(60, 64'd360360);
        wait_drained();
        write_modulus(rand64() | 64'h8000_0000_0000_0001);
        random_batches(60, mdl_modulus);
        wait_drained();

        if (error_count == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end
endmodule
